### design/lobm_pkg.sv
// Shared types, codes and helpers for the limit order book matcher.
package lobm_pkg;

    localparam int SIDE_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int FUNC_W         = 2;
    localparam int KIND_W         = 3;
    localparam int ID_W           = 32;
    localparam int PRICE_W        = 32;
    localparam int QTY_W          = 24;
    localparam int VER_W          = 16;
    localparam int LEFT_W         = QTY_W + 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXEC      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FOK_REJ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STALE     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]         op;
        logic [ID_W-1:0]           id;
        logic                      side;
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          qty;
        logic                      fok;
        logic [VER_W-1:0]          rver;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } qhead_t;

    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          volume;
        logic [ID_W-1:0]           key;
        logic [VER_W-1:0]          version;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           id;
        logic                      side;
        logic signed [PRICE_W-1:0] price;
        logic [QTY_W-1:0]          remaining;
        logic [QTY_W-1:0]          filled;
        logic signed [PRICE_W-1:0] fill_price;
        logic [VER_W-1:0]          version;
    } rec_t;

    // True when a resting price is reachable by an aggressor on aside
    function automatic logic crosses(input logic aside,
                                     input logic signed [PRICE_W-1:0] aprice,
                                     input logic signed [PRICE_W-1:0] rprice);
        crosses = aside ? (rprice >= aprice) : (rprice <= aprice);
    endfunction

endpackage

### design/limit_order_book_matcher.sv
// Flow: an unused request code is taken and dropped with no result; other requests
// scan the order store slot by slot, each slot read in a read state and checked in a check state.
// Each removal shifts the rest of its side one slot toward the front.
// Throughput: one request at a time in the engine; a 2-entry queue takes requests meanwhile.
// Reset: asynchronous, clears side counts, queue and output stage; store not cleared.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic [ID_W-1:0]           order_id,
    input  logic                      side,
    input  logic signed [PRICE_W-1:0] price,
    input  logic [QTY_W-1:0]          quantity,
    input  logic                      must_fill,
    input  logic [VER_W-1:0]          request_version,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [KIND_W-1:0]         kind,
    output logic [ID_W-1:0]           report_id,
    output logic                      report_side,
    output logic signed [PRICE_W-1:0] report_price,
    output logic [QTY_W-1:0]          remaining,
    output logic [QTY_W-1:0]          filled_volume,
    output logic signed [PRICE_W-1:0] fill_price,
    output logic [VER_W-1:0]          report_version,
    output logic                      last
);

    req_t   in_req;
    qhead_t head;
    logic   pop;
    rec_t   rec;

    // Pack the request transaction
    assign in_req = '{func, order_id, side, price, quantity, must_fill, request_version};

    lobm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .head     (head),
        .pop      (pop)
    );

    lobm_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (rec),
        .out_last  (last)
    );

    // Unpack the result transaction
    assign kind           = rec.kind;
    assign report_id      = rec.id;
    assign report_side    = rec.side;
    assign report_price   = rec.price;
    assign remaining      = rec.remaining;
    assign filled_volume  = rec.filled;
    assign fill_price     = rec.fill_price;
    assign report_version = rec.version;

endmodule

### design/lobm_front.sv
// Request intake: classifies requests and queues them for the book engine.
module lobm_front
    import lobm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  req_t   in_req,
    output qhead_t head,
    input  logic   pop
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    logic [QW:0]   cnt_reg;
    logic [QW-1:0] wp_reg;
    logic [QW-1:0] rp_reg;
    req_t          q_mem [QUEUE_DEPTH];
    logic          keep;
    logic          push;

    // Classify: unused request codes are taken and dropped
    always_comb
    begin
        unique case (in_req.op)
            FUNC_INSERT, FUNC_CANCEL, FUNC_UPDATE: keep = 1'b1;
            default:                               keep = 1'b0;
        endcase
    end

    assign in_ready   = (cnt_reg != (QW+1)'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign head.valid = (cnt_reg != '0);
    assign head.req   = q_mem[rp_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= in_req;
    end

endmodule

### design/lobm_back.sv
// Book engine: sequencer over the order store, matching and record output.
module lobm_back
    import lobm_pkg::*;
#(
    parameter int SIDE_DEPTH = SIDE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  qhead_t head,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output rec_t   out_rec,
    output logic   out_last
);

    localparam int IW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int AW = IW + 1;
    localparam int MEM_DEPTH = 2 << IW;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_FIND_RD   = 5'd1;
    localparam logic [4:0] ST_FIND_CHK  = 5'd2;
    localparam logic [4:0] ST_HIT       = 5'd3;
    localparam logic [4:0] ST_RM_RD     = 5'd4;
    localparam logic [4:0] ST_RM_WR     = 5'd5;
    localparam logic [4:0] ST_INS_START = 5'd6;
    localparam logic [4:0] ST_SUM_RD    = 5'd7;
    localparam logic [4:0] ST_SUM_CHK   = 5'd8;
    localparam logic [4:0] ST_INS_DEC   = 5'd9;
    localparam logic [4:0] ST_POS_RD    = 5'd10;
    localparam logic [4:0] ST_POS_CHK   = 5'd11;
    localparam logic [4:0] ST_SH_RD     = 5'd12;
    localparam logic [4:0] ST_SH_WR     = 5'd13;
    localparam logic [4:0] ST_PLACE     = 5'd14;
    localparam logic [4:0] ST_M_RD      = 5'd15;
    localparam logic [4:0] ST_M_CHK     = 5'd16;
    localparam logic [4:0] ST_AGG       = 5'd17;
    localparam logic [4:0] ST_DONE      = 5'd18;

    logic [4:0]               state_reg;
    logic [4:0]               ret_reg;
    req_t                     r_reg;
    entry_t                   e_reg;
    logic                     fs_reg;
    logic                     rs_reg;
    logic [CW-1:0]            i_reg;
    logic [CW-1:0]            j_reg;
    logic [CW-1:0]            pos_reg;
    logic signed [LEFT_W-1:0] left_reg;
    logic [QTY_W-1:0]         rem_reg;
    logic [QTY_W-1:0]         lfill_reg;
    logic signed [PRICE_W-1:0] lprice_reg;
    logic [VER_W-1:0]         ver_reg;
    logic                     ann_reg;
    logic [CW-1:0]            cnt_reg [2];
    logic                     held_valid_reg;
    rec_t                     held_reg;
    logic                     out_valid_reg;
    rec_t                     out_rec_reg;
    logic                     out_last_reg;

    entry_t                   mem [MEM_DEPTH];
    entry_t                   rd_q;
    logic                     re;
    logic [AW-1:0]            ra;
    logic                     we_c;
    logic                     we;
    logic [AW-1:0]            wa;
    entry_t                   wd;

    logic                     emit_req;
    rec_t                     emit_rec;
    logic                     out_free;
    logic                     emit_ok;
    logic                     go;
    logic                     oth;
    logic [CW-1:0]            jp1;
    logic [CW-1:0]            jm1;
    logic                     left_pos;
    logic                     stale;
    logic                     inplace;
    logic [VER_W-1:0]         nv;
    logic [VER_W-1:0]         agg_ver;
    logic [VER_W-1:0]         rv;
    logic                     is_full;

    assign oth      = ~r_reg.side;
    assign jp1      = j_reg + 1'b1;
    assign jm1      = j_reg - 1'b1;
    assign left_pos = !left_reg[LEFT_W-1] && (left_reg != '0);
    assign nv       = r_reg.rver + 1'b1;
    assign stale    = !(e_reg.version < r_reg.rver);
    assign inplace  = (fs_reg == r_reg.side) && (e_reg.price == r_reg.price)
                      && (r_reg.qty <= e_reg.volume);
    assign agg_ver  = ver_reg + 1'b1;
    assign rv       = rd_q.version + 1'b1;
    assign is_full  = (cnt_reg[r_reg.side] == CW'(SIDE_DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign emit_ok  = !held_valid_reg || out_free;
    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign we       = we_c && go;

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;
    assign out_last  = out_last_reg;

    // Decode memory accesses and record emission for the current step
    always_comb
    begin
        re       = 1'b0;
        ra       = '0;
        we_c     = 1'b0;
        wa       = '0;
        wd       = '0;
        emit_req = 1'b0;
        emit_rec = '0;
        go       = 1'b1;
        unique case (state_reg)
            ST_FIND_RD:
            begin
                re = 1'b1;
                ra = {fs_reg, i_reg[IW-1:0]};
                if (!(i_reg < cnt_reg[fs_reg]) && fs_reg)
                begin
                    emit_req = 1'b1;
                    emit_rec = '{KIND_UNKNOWN, r_reg.id, r_reg.side, r_reg.price,
                                 r_reg.qty, '0, '0, '0};
                end
            end
            ST_HIT:
            begin
                emit_req = 1'b1;
                if (r_reg.op == FUNC_CANCEL)
                    emit_rec = '{KIND_CANCELLED, e_reg.key, fs_reg, e_reg.price,
                                 e_reg.volume, '0, '0, e_reg.version};
                else if (stale)
                    emit_rec = '{KIND_STALE, e_reg.key, fs_reg, e_reg.price,
                                 e_reg.volume, '0, '0, e_reg.version};
                else
                begin
                    emit_rec = '{KIND_UPDATED, r_reg.id, r_reg.side, r_reg.price,
                                 r_reg.qty, '0, '0, nv};
                    if (inplace)
                    begin
                        we_c = 1'b1;
                        wa   = {fs_reg, i_reg[IW-1:0]};
                        wd   = '{e_reg.price, r_reg.qty, e_reg.key, nv};
                    end
                end
            end
            ST_RM_RD:
            begin
                re = 1'b1;
                ra = {rs_reg, jp1[IW-1:0]};
            end
            ST_RM_WR:
            begin
                we_c = 1'b1;
                wa   = {rs_reg, j_reg[IW-1:0]};
                wd   = rd_q;
            end
            ST_SUM_RD, ST_M_RD:
            begin
                re = 1'b1;
                ra = {oth, i_reg[IW-1:0]};
            end
            ST_INS_DEC:
            begin
                if (r_reg.fok && left_pos)
                begin
                    emit_req = 1'b1;
                    emit_rec = '{KIND_FOK_REJ, r_reg.id, r_reg.side, r_reg.price,
                                 r_reg.qty, '0, '0, ver_reg};
                end
                else if (is_full)
                begin
                    emit_req = 1'b1;
                    emit_rec = '{KIND_FULL, r_reg.id, r_reg.side, r_reg.price,
                                 r_reg.qty, '0, '0, ver_reg};
                end
            end
            ST_POS_RD:
            begin
                re = 1'b1;
                ra = {r_reg.side, pos_reg[IW-1:0]};
            end
            ST_SH_RD:
            begin
                re = 1'b1;
                ra = {r_reg.side, jm1[IW-1:0]};
            end
            ST_SH_WR:
            begin
                we_c = 1'b1;
                wa   = {r_reg.side, j_reg[IW-1:0]};
                wd   = rd_q;
            end
            ST_PLACE:
            begin
                we_c = 1'b1;
                wa   = {r_reg.side, pos_reg[IW-1:0]};
                wd   = '{r_reg.price, r_reg.qty, r_reg.id, ver_reg};
                if (ann_reg)
                begin
                    emit_req = 1'b1;
                    emit_rec = '{KIND_INSERTED, r_reg.id, r_reg.side, r_reg.price,
                                 r_reg.qty, '0, '0, ver_reg};
                end
            end
            ST_M_CHK:
            begin
                if (crosses(r_reg.side, r_reg.price, rd_q.price))
                begin
                    emit_req = 1'b1;
                    if (rem_reg >= rd_q.volume)
                        emit_rec = '{KIND_EXEC, rd_q.key, oth, rd_q.price, '0,
                                     rd_q.volume, rd_q.price, rv};
                    else
                    begin
                        emit_rec = '{KIND_EXEC, rd_q.key, oth, rd_q.price,
                                     rd_q.volume - rem_reg, rem_reg, rd_q.price, rv};
                        we_c = 1'b1;
                        wa   = {oth, i_reg[IW-1:0]};
                        wd   = '{rd_q.price, rd_q.volume - rem_reg, rd_q.key, rv};
                    end
                end
            end
            ST_AGG:
            begin
                emit_req = 1'b1;
                emit_rec = '{KIND_EXEC, r_reg.id, r_reg.side, r_reg.price, rem_reg,
                             lfill_reg, lprice_reg, agg_ver};
                if (rem_reg != '0)
                begin
                    we_c = 1'b1;
                    wa   = {r_reg.side, pos_reg[IW-1:0]};
                    wd   = '{r_reg.price, rem_reg, r_reg.id, agg_ver};
                end
            end
            ST_DONE:
                go = !held_valid_reg || out_free;
            default:
            begin
            end
        endcase
        if (emit_req)
            go = emit_ok;
    end

    // Order store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_q <= mem[ra];
    end

    // Hold payload of the output stage
    always_ff @(posedge clk)
    begin
        if (emit_req && go && held_valid_reg)
        begin
            out_rec_reg  <= held_reg;
            out_last_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && go && held_valid_reg)
        begin
            out_rec_reg  <= held_reg;
            out_last_reg <= 1'b1;
        end
        if (emit_req && go)
            held_reg <= emit_rec;
    end

    // Sequence each request through the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            cnt_reg[0]     <= '0;
            cnt_reg[1]     <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            r_reg          <= '0;
            e_reg          <= '0;
            fs_reg         <= 1'b0;
            rs_reg         <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
            left_reg       <= '0;
            rem_reg        <= '0;
            lfill_reg      <= '0;
            lprice_reg     <= '0;
            ver_reg        <= '0;
            ann_reg        <= 1'b0;
        end
        else
        begin
            // Output stage: a held record moves out when the next one arrives or the request finishes
            if ((emit_req && go && held_valid_reg) ||
                (state_reg == ST_DONE && go && held_valid_reg))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (emit_req && go)
                held_valid_reg <= 1'b1;
            else if (state_reg == ST_DONE && go)
                held_valid_reg <= 1'b0;

            if (go)
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (head.valid)
                        begin
                            r_reg  <= head.req;
                            fs_reg <= 1'b0;
                            i_reg  <= '0;
                            case (head.req.op)
                                FUNC_INSERT:
                                begin
                                    ver_reg   <= VER_W'(1);
                                    ann_reg   <= 1'b1;
                                    state_reg <= ST_INS_START;
                                end
                                FUNC_CANCEL, FUNC_UPDATE:
                                    state_reg <= ST_FIND_RD;
                                default:
                                    state_reg <= ST_DONE;
                            endcase
                        end
                    end
                    ST_FIND_RD:
                    begin
                        if (i_reg < cnt_reg[fs_reg])
                            state_reg <= ST_FIND_CHK;
                        else if (!fs_reg)
                        begin
                            fs_reg <= 1'b1;
                            i_reg  <= '0;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                    ST_FIND_CHK:
                    begin
                        if (rd_q.key == r_reg.id)
                        begin
                            e_reg     <= rd_q;
                            state_reg <= ST_HIT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_FIND_RD;
                        end
                    end
                    ST_HIT:
                    begin
                        if (r_reg.op == FUNC_CANCEL)
                        begin
                            rs_reg    <= fs_reg;
                            j_reg     <= i_reg;
                            ret_reg   <= ST_DONE;
                            state_reg <= ST_RM_RD;
                        end
                        else if (stale || inplace)
                            state_reg <= ST_DONE;
                        else
                        begin
                            rs_reg    <= fs_reg;
                            j_reg     <= i_reg;
                            ret_reg   <= ST_INS_START;
                            ver_reg   <= nv + 1'b1;
                            ann_reg   <= 1'b0;
                            state_reg <= ST_RM_RD;
                        end
                    end
                    ST_RM_RD:
                    begin
                        if (jp1 < cnt_reg[rs_reg])
                            state_reg <= ST_RM_WR;
                        else
                        begin
                            cnt_reg[rs_reg] <= cnt_reg[rs_reg] - 1'b1;
                            state_reg       <= ret_reg;
                        end
                    end
                    ST_RM_WR:
                    begin
                        j_reg     <= jp1;
                        state_reg <= ST_RM_RD;
                    end
                    ST_INS_START:
                    begin
                        i_reg     <= '0;
                        left_reg  <= $signed({2'b00, r_reg.qty});
                        state_reg <= ST_SUM_RD;
                    end
                    ST_SUM_RD:
                    begin
                        if ((i_reg < cnt_reg[oth]) && left_pos)
                            state_reg <= ST_SUM_CHK;
                        else
                            state_reg <= ST_INS_DEC;
                    end
                    ST_SUM_CHK:
                    begin
                        if (crosses(r_reg.side, r_reg.price, rd_q.price))
                        begin
                            left_reg  <= left_reg - $signed({2'b00, rd_q.volume});
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_SUM_RD;
                        end
                        else
                            state_reg <= ST_INS_DEC;
                    end
                    ST_INS_DEC:
                    begin
                        if ((r_reg.fok && left_pos) || is_full)
                            state_reg <= ST_DONE;
                        else
                        begin
                            pos_reg   <= '0;
                            state_reg <= ST_POS_RD;
                        end
                    end
                    ST_POS_RD:
                    begin
                        if (pos_reg < cnt_reg[r_reg.side])
                            state_reg <= ST_POS_CHK;
                        else
                        begin
                            j_reg     <= cnt_reg[r_reg.side];
                            state_reg <= ST_SH_RD;
                        end
                    end
                    ST_POS_CHK:
                    begin
                        // Equal prices queue behind the resting order
                        if (r_reg.side ? (r_reg.price >= rd_q.price)
                                       : (r_reg.price <= rd_q.price))
                        begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= ST_POS_RD;
                        end
                        else
                        begin
                            j_reg     <= cnt_reg[r_reg.side];
                            state_reg <= ST_SH_RD;
                        end
                    end
                    ST_SH_RD:
                    begin
                        if (j_reg > pos_reg)
                            state_reg <= ST_SH_WR;
                        else
                            state_reg <= ST_PLACE;
                    end
                    ST_SH_WR:
                    begin
                        j_reg     <= jm1;
                        state_reg <= ST_SH_RD;
                    end
                    ST_PLACE:
                    begin
                        cnt_reg[r_reg.side] <= cnt_reg[r_reg.side] + 1'b1;
                        if ((left_reg >= $signed({2'b00, r_reg.qty})) && (r_reg.qty != '0))
                            state_reg <= ST_DONE;
                        else
                        begin
                            rem_reg    <= r_reg.qty;
                            i_reg      <= '0;
                            lfill_reg  <= '0;
                            lprice_reg <= '0;
                            state_reg  <= ST_M_RD;
                        end
                    end
                    ST_M_RD:
                    begin
                        if ((i_reg < cnt_reg[oth]) && (rem_reg != '0))
                            state_reg <= ST_M_CHK;
                        else
                            state_reg <= ST_AGG;
                    end
                    ST_M_CHK:
                    begin
                        if (crosses(r_reg.side, r_reg.price, rd_q.price))
                        begin
                            lprice_reg <= rd_q.price;
                            if (rem_reg >= rd_q.volume)
                            begin
                                lfill_reg <= rd_q.volume;
                                rem_reg   <= rem_reg - rd_q.volume;
                                rs_reg    <= oth;
                                j_reg     <= i_reg;
                                ret_reg   <= ST_M_RD;
                                state_reg <= ST_RM_RD;
                            end
                            else
                            begin
                                lfill_reg <= rem_reg;
                                rem_reg   <= '0;
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= ST_M_RD;
                            end
                        end
                        else
                            state_reg <= ST_AGG;
                    end
                    ST_AGG:
                    begin
                        if (rem_reg == '0)
                        begin
                            rs_reg    <= r_reg.side;
                            j_reg     <= pos_reg;
                            ret_reg   <= ST_DONE;
                            state_reg <= ST_RM_RD;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                    ST_DONE:
                        state_reg <= ST_IDLE;
                    default:
                        state_reg <= ST_IDLE;
                endcase
            end
        end
    end

endmodule

### design/lobm_checker.sv
// Port-level checks for the limit order book matcher, bound to the top level.
module lobm_checker
    import lobm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [KIND_W-1:0]         kind,
    input logic [ID_W-1:0]           report_id,
    input logic [QTY_W-1:0]          filled_volume,
    input logic signed [PRICE_W-1:0] fill_price,
    input logic [VER_W-1:0]          report_version,
    input logic                      last
);

    // A waiting request transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request dropped while waiting");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(report_id)
                                    && $stable(last))
        else $error("result changed while stalled");

    // Only executions carry fill data
    a_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_EXEC |-> filled_volume == '0 && fill_price == '0)
        else $error("fill data on a non-execution record");

    // Terminal reports close the request
    a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CANCELLED || kind == KIND_STALE || kind == KIND_UNKNOWN
                      || kind == KIND_FOK_REJ || kind == KIND_FULL) |-> last)
        else $error("terminal report not marked last");

    // Unknown identifiers report version zero
    a_unknown_ver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_UNKNOWN |-> report_version == '0)
        else $error("unknown report with non-zero version");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

### verif/limit_order_book_matcher_tb.sv
// Self-checking testbench for the limit order book matcher.
`timescale 1ns / 1ps

module limit_order_book_matcher_tb
    import lobm_pkg::*;
();

    localparam int DEPTH      = SIDE_DEPTH_DEF;
    localparam int WDOG_LIMIT = 40000;
    localparam int DRAIN_CYC  = 800;

    typedef struct {
        rec_t rec;
        logic last;
    } report_t;

    typedef struct {
        req_t req;
        int   typed;
        int   tkind;
        int   tver;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func;
    logic [ID_W-1:0]           order_id;
    logic                      side;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          quantity;
    logic                      must_fill;
    logic [VER_W-1:0]          request_version;
    logic                      out_valid;
    logic                      out_ready;
    logic [KIND_W-1:0]         kind;
    logic [ID_W-1:0]           report_id;
    logic                      report_side;
    logic signed [PRICE_W-1:0] report_price;
    logic [QTY_W-1:0]          remaining;
    logic [QTY_W-1:0]          filled_volume;
    logic signed [PRICE_W-1:0] fill_price;
    logic [VER_W-1:0]          report_version;
    logic                      last;

    // predicted book
    entry_t book [2][DEPTH];
    int     book_cnt [2];
    report_t pending_reports [$];
    report_t scratch [$];

    int errors;
    int n_sent;
    int n_reports;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit timed_out;

    limit_order_book_matcher u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .order_id(order_id), .side(side), .price(price),
        .quantity(quantity), .must_fill(must_fill),
        .request_version(request_version),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .report_id(report_id), .report_side(report_side),
        .report_price(report_price), .remaining(remaining),
        .filled_volume(filled_volume), .fill_price(fill_price),
        .report_version(report_version), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Book predictor

    function automatic void emit_rec(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                     input logic s, input logic signed [PRICE_W-1:0] p,
                                     input logic [QTY_W-1:0] rem, input logic [QTY_W-1:0] fv,
                                     input logic signed [PRICE_W-1:0] fp,
                                     input logic [VER_W-1:0] v);
        report_t r;
        r.rec = '{kind: k, id: id, side: s, price: p, remaining: rem, filled: fv,
                  fill_price: fp, version: v};
        r.last = 1'b0;
        scratch.push_back(r);
    endfunction

    function automatic void drop_entry(input int s, input int i);
        for (int j = i; j + 1 < book_cnt[s]; j++)
            book[s][j] = book[s][j+1];
        book_cnt[s]--;
    endfunction

    function automatic bit reaches(input logic aside, input logic signed [PRICE_W-1:0] ap,
                                   input logic signed [PRICE_W-1:0] rp);
        return aside ? (rp >= ap) : (rp <= ap);
    endfunction

    function automatic void place_order(input logic [ID_W-1:0] id, input logic s,
                                        input logic signed [PRICE_W-1:0] p,
                                        input logic [QTY_W-1:0] q, input logic fok,
                                        input logic [VER_W-1:0] startver, input bit announce);
        int o;
        int pos;
        int i;
        longint unsigned_left;
        longint rem;
        logic [VER_W-1:0] v;
        logic [VER_W-1:0] rv;
        logic [QTY_W-1:0] lastfill;
        logic signed [PRICE_W-1:0] lastprice;
        o = s ? 0 : 1;
        v = startver + 1'b1;
        lastfill = '0;
        lastprice = '0;
        // sum the crossing volume first
        unsigned_left = longint'(q);
        for (i = 0; i < book_cnt[o] && unsigned_left > 0 && reaches(s, p, book[o][i].price); i++)
            unsigned_left -= longint'(book[o][i].volume);
        if (fok && unsigned_left > 0)
        begin
            emit_rec(KIND_FOK_REJ, id, s, p, q, '0, '0, v);
            return;
        end
        if (book_cnt[s] >= DEPTH)
        begin
            emit_rec(KIND_FULL, id, s, p, q, '0, '0, v);
            return;
        end
        // place behind equal prices
        pos = 0;
        while (pos < book_cnt[s] && (s ? (p >= book[s][pos].price) : (p <= book[s][pos].price)))
            pos++;
        for (int j = book_cnt[s]; j > pos; j--)
            book[s][j] = book[s][j-1];
        book_cnt[s]++;
        book[s][pos] = '{price: p, volume: q, key: id, version: v};
        if (announce)
            emit_rec(KIND_INSERTED, id, s, p, q, '0, '0, v);
        if (unsigned_left >= longint'(q) && q != 0)
            return;
        // match best first
        rem = longint'(q);
        i = 0;
        while (i < book_cnt[o] && rem > 0 && reaches(s, p, book[o][i].price))
        begin
            rv = book[o][i].version + 1'b1;
            book[o][i].version = rv;
            lastprice = book[o][i].price;
            if (rem >= longint'(book[o][i].volume))
            begin
                lastfill = book[o][i].volume;
                rem -= longint'(lastfill);
                emit_rec(KIND_EXEC, book[o][i].key, o[0], lastprice, '0, lastfill,
                         lastprice, rv);
                drop_entry(o, i);
            end
            else
            begin
                lastfill = rem[QTY_W-1:0];
                book[o][i].volume -= lastfill;
                rem = 0;
                emit_rec(KIND_EXEC, book[o][i].key, o[0], lastprice, book[o][i].volume,
                         lastfill, lastprice, rv);
                i++;
            end
        end
        v = v + 1'b1;
        emit_rec(KIND_EXEC, id, s, p, rem[QTY_W-1:0], lastfill, lastprice, v);
        if (rem == 0)
            drop_entry(s, pos);
        else
        begin
            book[s][pos].volume = rem[QTY_W-1:0];
            book[s][pos].version = v;
        end
    endfunction

    function automatic void book_apply(input req_t r);
        int fs;
        int fi;
        bit found;
        logic [VER_W-1:0] nv;
        scratch.delete();
        found = 1'b0;
        if (r.op == FUNC_INSERT)
            place_order(r.id, r.side, r.price, r.qty, r.fok, '0, 1'b1);
        else if (r.op == FUNC_CANCEL || r.op == FUNC_UPDATE)
        begin
            for (int s = 0; s < 2 && !found; s++)
                for (int i = 0; i < book_cnt[s] && !found; i++)
                    if (book[s][i].key == r.id)
                    begin
                        found = 1'b1;
                        fs = s;
                        fi = i;
                    end
            if (!found)
                emit_rec(KIND_UNKNOWN, r.id, r.side, r.price, r.qty, '0, '0, '0);
            else if (r.op == FUNC_CANCEL)
            begin
                emit_rec(KIND_CANCELLED, book[fs][fi].key, fs[0], book[fs][fi].price,
                         book[fs][fi].volume, '0, '0, book[fs][fi].version);
                drop_entry(fs, fi);
            end
            else if (!(book[fs][fi].version < r.rver))
                emit_rec(KIND_STALE, book[fs][fi].key, fs[0], book[fs][fi].price,
                         book[fs][fi].volume, '0, '0, book[fs][fi].version);
            else
            begin
                nv = r.rver + 1'b1;
                emit_rec(KIND_UPDATED, r.id, r.side, r.price, r.qty, '0, '0, nv);
                if (fs == r.side && book[fs][fi].price == r.price
                    && r.qty <= book[fs][fi].volume)
                begin
                    book[fs][fi].volume = r.qty;
                    book[fs][fi].version = nv;
                end
                else
                begin
                    drop_entry(fs, fi);
                    place_order(r.id, r.side, r.price, r.qty, r.fok, nv, 1'b0);
                end
            end
        end
        if (scratch.size() > 0)
            scratch[scratch.size()-1].last = 1'b1;
    endfunction

    // Checking

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // check each result transaction and keep the watchdog
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                n_reports++;
                if (pending_reports.size() == 0)
                    report_mismatch($sformatf("unexpected record kind %0d id %0h",
                                              kind, report_id));
                else
                begin
                    e = pending_reports.pop_front();
                    if (kind !== e.rec.kind)
                        report_mismatch($sformatf("kind %0d exp %0d", kind, e.rec.kind));
                    if (report_id !== e.rec.id)
                        report_mismatch($sformatf("report_id %0h exp %0h", report_id, e.rec.id));
                    if (report_side !== e.rec.side)
                        report_mismatch($sformatf("report_side %0b exp %0b", report_side,
                                                  e.rec.side));
                    if (report_price !== e.rec.price)
                        report_mismatch($sformatf("report_price %0d exp %0d", report_price,
                                                  e.rec.price));
                    if (remaining !== e.rec.remaining)
                        report_mismatch($sformatf("remaining %0d exp %0d", remaining,
                                                  e.rec.remaining));
                    if (filled_volume !== e.rec.filled)
                        report_mismatch($sformatf("filled_volume %0d exp %0d", filled_volume,
                                                  e.rec.filled));
                    if (fill_price !== e.rec.fill_price)
                        report_mismatch($sformatf("fill_price %0d exp %0d", fill_price,
                                                  e.rec.fill_price));
                    if (report_version !== e.rec.version)
                        report_mismatch($sformatf("report_version %0d exp %0d", report_version,
                                                  e.rec.version));
                    if (last !== e.last)
                        report_mismatch($sformatf("last %0b exp %0b", last, e.last));
                end
            end
        end
        else
            idle_cycles <= 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus

    task automatic send_request(input req_t r, input int typed, input int tkind,
                                input int tver);
        report_t t;
        // hold off at random
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        func = r.op;
        order_id = r.id;
        side = r.side;
        price = r.price;
        quantity = r.qty;
        must_fill = r.fok;
        request_version = r.rver;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
        book_apply(r);
        if (typed != 0)
        begin
            t.rec = '{kind: KIND_W'(tkind), id: r.id, side: r.side, price: r.price,
                      remaining: r.qty, filled: '0, fill_price: '0, version: VER_W'(tver)};
            t.last = 1'b1;
            pending_reports.push_back(t);
        end
        else
            foreach (scratch[i])
                pending_reports.push_back(scratch[i]);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic req_t mk(input logic [FUNC_W-1:0] op, input int id, input int s,
                                input int p, input int q, input int fok, input int rv);
        return '{op: op, id: ID_W'(id), side: s[0], price: PRICE_W'(p), qty: QTY_W'(q),
                 fok: fok[0], rver: VER_W'(rv)};
    endfunction

    function automatic req_t random_request();
        req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.op = (pick < 45) ? FUNC_INSERT : (pick < 65) ? FUNC_CANCEL :
               (pick < 95) ? FUNC_UPDATE : FUNC_UNUSED;
        r.id = ($urandom_range(0, 19) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
        r.side = 1'($urandom_range(0, 1));
        r.price = ($urandom_range(0, 9) == 0) ? PRICE_W'($urandom)
                                              : PRICE_W'($urandom_range(90, 110));
        pick = $urandom_range(0, 19);
        r.qty = (pick == 0) ? '0 : (pick == 1) ? QTY_W'($urandom)
                                               : QTY_W'($urandom_range(1, 100));
        r.fok = ($urandom_range(0, 4) == 0);
        r.rver = ($urandom_range(0, 9) == 0) ? VER_W'($urandom) : VER_W'($urandom_range(0, 20));
        return r;
    endfunction

    initial
    begin
        row_t rows [$];
        req_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_INSERT;
        order_id = '0;
        side = 1'b0;
        price = '0;
        quantity = '0;
        must_fill = 1'b0;
        request_version = '0;
        n_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows: unknown ids, rejected fill-or-kill, extremes, stale and updates
        rows.push_back('{mk(FUNC_CANCEL, 5, 0, 0, 0, 0, 0), 1, int'(KIND_UNKNOWN), 0});
        rows.push_back('{mk(FUNC_UPDATE, 32'hFFFF_FFFF, 1, -1, 32'h00FF_FFFF, 1, 32'h0000_FFFF),
                         1, int'(KIND_UNKNOWN), 0});
        rows.push_back('{mk(FUNC_INSERT, 9, 0, 100, 50, 1, 0), 1, int'(KIND_FOK_REJ), 1});
        rows.push_back('{mk(FUNC_INSERT, 1, 0, 100, 50, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 2, 0, 100, 30, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 3, 0, 32'sh7FFF_FFFF, 10, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 4, 1, 32'sh8000_0000, 32'h00FF_FFFF, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 5, 1, 200, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 6, 0, 150, 20, 1, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 4, 1, 32'sh8000_0000, 100, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 4, 1, 32'sh8000_0000, 100, 0, 32'h0000_FFFF), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 4, 1, 500, 100, 0, 1), 0, 0, 0});
        rows.push_back('{mk(FUNC_CANCEL, 4, 0, 0, 0, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_UNUSED, 7, 1, 1, 1, 1, 1), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 32'hFFFF_FFFF, 1, 300, 100, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 0, 0, 250, 10, 0, 0), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 0, 0, 400, 200, 1, 5), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 32'hFFFF_FFFF, 1, 300, 40, 0, 9), 0, 0, 0});
        rows.push_back('{mk(FUNC_UPDATE, 32'hFFFF_FFFF, 0, 350, 40, 0, 12), 0, 0, 0});
        rows.push_back('{mk(FUNC_INSERT, 11, 1, 340, 60, 0, 0), 0, 0, 0});
        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].tkind, rows[i].tver);

        // random phases under different back-pressure; fill the ask side in one of them
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 28 : 0;
            recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 28 : 0;
            if (ph == 2)
            begin
                for (int k = 0; k <= DEPTH; k++)
                    send_request(mk(FUNC_INSERT, 1000 + k, 1, 32'sh7FFF_FF00 + k,
                                    $urandom_range(1, 50), 0, 0), 0, 0, 0);
                for (int k = 0; k <= DEPTH; k++)
                    send_request(mk(FUNC_CANCEL, 1000 + k, 1, 0, 0, 0, 0), 0, 0, 0);
            end
            for (int n = 0; n < 41; n++)
            begin
                r = random_request();
                send_request(r, 0, 0, 0);
            end
        end

        // drain outstanding records, then allow the engine to settle
        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Sent %0d requests and checked %0d records, four back-pressure mixes,",
                 n_sent, n_reports);
        $display("including a full ask side, fill-or-kill, stale and reinserting updates.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### limit_order_book_matcher.f
design/lobm_pkg.sv
design/lobm_front.sv
design/lobm_back.sv
design/limit_order_book_matcher.sv
design/lobm_checker.sv
verif/limit_order_book_matcher_tb.sv
